[src/hmmbc_pkg.sv]
// ----------------------------------------------------------------------------
// hmmbc_pkg: shared types and constants of the memory map / bank controller
// Region, action and error codes, the bus address map and the structs that
// carry configuration, bank state and one result beat between modules.
// ----------------------------------------------------------------------------
package hmmbc_pkg;

	// Bank count ceilings and floors for this build.
	localparam logic [7:0] MAX_ROM_BANKS = 8'd128;
	localparam logic [4:0] MAX_RAM_BANKS = 5'd16;
	localparam logic [7:0] MIN_ROM_BANKS = 8'd2;
	localparam logic [4:0] MIN_RAM_BANKS = 5'd1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CTRL_TYPE = 2'd0;
	localparam logic [1:0] CFG_ROM_COUNT = 2'd1;
	localparam logic [1:0] CFG_RAM_COUNT = 2'd2;

	// Controller types.
	localparam logic [1:0] CT_PLAIN       = 2'd0;
	localparam logic [1:0] CT_BANKED_A    = 2'd1;
	localparam logic [1:0] CT_BANKED_B    = 2'd2;
	localparam logic [1:0] CT_UNSUPPORTED = 2'd3;

	// Bus commands.
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// Byte that arms the cart RAM enable latch.
	localparam logic [7:0] RAM_EN_KEY = 8'h0a;

	// Address map boundaries.
	localparam logic [15:0] ADDR_BANK_LO   = 16'h2000;
	localparam logic [15:0] ADDR_BANK_HI   = 16'h4000;
	localparam logic [15:0] ADDR_MODE      = 16'h6000;
	localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
	localparam logic [15:0] ADDR_CRAM      = 16'ha000;
	localparam logic [15:0] ADDR_WRAM      = 16'hc000;
	localparam logic [15:0] ADDR_ECHO      = 16'he000;
	localparam logic [15:0] ADDR_OAM_LO    = 16'hfe00;
	localparam logic [15:0] ADDR_OAM_HI    = 16'hfe9f;
	localparam logic [15:0] ADDR_IO_LO     = 16'hff00;
	localparam logic [15:0] ADDR_IO_HI     = 16'hff7f;
	localparam logic [15:0] ADDR_HRAM_LO   = 16'hff80;
	localparam logic [15:0] ADDR_HRAM_HI   = 16'hfffe;
	localparam logic [15:0] ADDR_IE        = 16'hffff;
	localparam logic [15:0] ADDR_DIV       = 16'hff04;
	localparam logic [15:0] ADDR_TAC       = 16'hff07;
	localparam logic [15:0] ADDR_LY        = 16'hff44;
	localparam logic [15:0] ADDR_DMA       = 16'hff46;
	localparam logic [15:0] ADDR_BOOT_OFF  = 16'hff50;

	typedef enum logic [3:0] {
		REG_BOOT_ROM = 4'd0,
		REG_CART_ROM = 4'd1,
		REG_VRAM     = 4'd2,
		REG_CART_RAM = 4'd3,
		REG_WRAM     = 4'd4,
		REG_OAM      = 4'd5,
		REG_IO       = 4'd6,
		REG_HRAM     = 4'd7,
		REG_IE       = 4'd8,
		REG_NONE     = 4'd9
	} region_t;

	typedef enum logic [2:0] {
		SIDE_NONE      = 3'd0,
		SIDE_DIV_CLR   = 3'd1,
		SIDE_TIMER     = 3'd2,
		SIDE_LINE_CLR  = 3'd3,
		SIDE_DMA_START = 3'd4
	} side_t;

	typedef enum logic [2:0] {
		ERR_OK         = 3'd0,
		ERR_UNMAPPED   = 3'd1,
		ERR_ROM_CLAMP  = 3'd2,
		ERR_RAM_CLAMP  = 3'd3,
		ERR_BAD_MODE   = 3'd4,
		ERR_BAD_CTRL   = 3'd5
	} err_t;

	typedef struct packed {
		logic [1:0] ctrl_type;
		logic [7:0] rom_count;
		logic [4:0] ram_count;
	} cfg_t;

	typedef struct packed {
		logic [6:0] rom_sel;
		logic [3:0] ram_sel;
		logic       mode;
		logic       ram_en;
		logic       boot_off;
		logic [1:0] tsel;
	} bank_state_t;

	typedef struct packed {
		region_t     region;
		logic [20:0] offset;
		logic [7:0]  store_data;
		logic        store_en;
		side_t       side;
		logic [7:0]  dma_page;
		err_t        err;
		logic        ram_en;
	} rsp_t;

endpackage

[src/hmmbc_decode.sv]
// ----------------------------------------------------------------------------
// hmmbc_decode: single-access decoder
// Maps one bus access to a region and offset, applies controller register
// writes and I/O side actions, and returns the bank state after the access.
// ----------------------------------------------------------------------------
module hmmbc_decode (
	input  logic                  cmd,
	input  logic [15:0]           addr,
	input  logic [7:0]            data,
	input  hmmbc_pkg::cfg_t       cfg,
	input  hmmbc_pkg::bank_state_t cur,
	output hmmbc_pkg::bank_state_t nxt,
	output hmmbc_pkg::rsp_t       rsp
);

	logic [7:0] rom_lim;
	logic [4:0] ram_lim;

	// Returns {clamped, bank}; a zero bank reads as one after the clamp.
	function automatic logic [7:0] fit_rom(input logic [6:0] v, input logic [7:0] lim);
		logic [6:0] b;
		logic       c;
		b = v;
		c = 1'b0;
		if ({1'b0, v} >= lim) begin
			b = 7'(lim - 8'd1);
			c = 1'b1;
		end
		if (b == 7'd0)
			b = 7'd1;
		return {c, b};
	endfunction

	function automatic logic [4:0] fit_ram(input logic [7:0] v, input logic [4:0] lim);
		logic [3:0] b;
		logic       c;
		b = v[3:0];
		c = 1'b0;
		if (v >= {3'b000, lim}) begin
			b = 4'(lim - 5'd1);
			c = 1'b1;
		end
		return {c, b};
	endfunction

	always_comb begin
		rom_lim = cfg.rom_count;
		if (rom_lim < hmmbc_pkg::MIN_ROM_BANKS)
			rom_lim = hmmbc_pkg::MIN_ROM_BANKS;
		else if (rom_lim > hmmbc_pkg::MAX_ROM_BANKS)
			rom_lim = hmmbc_pkg::MAX_ROM_BANKS;
		ram_lim = cfg.ram_count;
		if (ram_lim < hmmbc_pkg::MIN_RAM_BANKS)
			ram_lim = hmmbc_pkg::MIN_RAM_BANKS;
		else if (ram_lim > hmmbc_pkg::MAX_RAM_BANKS)
			ram_lim = hmmbc_pkg::MAX_RAM_BANKS;
	end

	always_comb begin
		logic [6:0] rom_cand;
		logic [7:0] rom_fit;
		logic [4:0] ram_fit;
		logic       wr;
		logic       mapped;

		wr       = (cmd == hmmbc_pkg::CMD_WRITE);
		nxt      = cur;
		rom_cand = 7'd0;
		rom_fit  = fit_rom(7'd0, rom_lim);
		ram_fit  = fit_ram(8'd0, ram_lim);
		mapped   = 1'b1;
		rsp            = '0;
		rsp.region     = hmmbc_pkg::REG_NONE;
		rsp.side       = hmmbc_pkg::SIDE_NONE;
		rsp.err        = hmmbc_pkg::ERR_OK;

		if (cfg.ctrl_type == hmmbc_pkg::CT_UNSUPPORTED) begin
			rsp.err = hmmbc_pkg::ERR_BAD_CTRL;
		end else if (!addr[15]) begin
			if (wr) begin
				if (addr < hmmbc_pkg::ADDR_BANK_LO) begin
					nxt.ram_en = (data == hmmbc_pkg::RAM_EN_KEY);
				end else if (cfg.ctrl_type == hmmbc_pkg::CT_PLAIN) begin
					rsp.err = hmmbc_pkg::ERR_UNMAPPED;
				end else if (addr < hmmbc_pkg::ADDR_BANK_HI) begin
					rom_cand = (cfg.ctrl_type == hmmbc_pkg::CT_BANKED_A) ?
						{2'b00, data[4:0]} : data[6:0];
					rom_fit = fit_rom(rom_cand, rom_lim);
					nxt.rom_sel = rom_fit[6:0];
					if (rom_fit[7])
						rsp.err = hmmbc_pkg::ERR_ROM_CLAMP;
				end else if (addr < hmmbc_pkg::ADDR_MODE) begin
					if (cfg.ctrl_type == hmmbc_pkg::CT_BANKED_A && !cur.mode) begin
						// upper ROM bank bits
						rom_cand = {data[1:0], cur.rom_sel[4:0]};
						rom_fit = fit_rom(rom_cand, rom_lim);
						nxt.rom_sel = rom_fit[6:0];
						if (rom_fit[7])
							rsp.err = hmmbc_pkg::ERR_ROM_CLAMP;
					end else begin
						ram_fit = fit_ram((cfg.ctrl_type == hmmbc_pkg::CT_BANKED_A) ?
							{6'd0, data[1:0]} : data, ram_lim);
						nxt.ram_sel = ram_fit[3:0];
						if (ram_fit[4])
							rsp.err = hmmbc_pkg::ERR_RAM_CLAMP;
					end
				end else begin
					if (data == 8'd0)
						nxt.mode = 1'b0;
					else if (data == 8'd1)
						nxt.mode = 1'b1;
					else
						rsp.err = hmmbc_pkg::ERR_BAD_MODE;
				end
			end else if (addr < hmmbc_pkg::ADDR_BANK_HI ||
					cfg.ctrl_type == hmmbc_pkg::CT_PLAIN) begin
				rsp.region = (!cur.boot_off && addr < hmmbc_pkg::ADDR_BOOT_END) ?
					hmmbc_pkg::REG_BOOT_ROM : hmmbc_pkg::REG_CART_ROM;
				rsp.offset = {5'd0, addr};
			end else begin
				rsp.region = hmmbc_pkg::REG_CART_ROM;
				rsp.offset = {cur.rom_sel, addr[13:0]};
			end
		end else begin
			if (addr < hmmbc_pkg::ADDR_CRAM) begin
				rsp.region = hmmbc_pkg::REG_VRAM;
				rsp.offset = {8'd0, addr[12:0]};
			end else if (addr < hmmbc_pkg::ADDR_WRAM) begin
				rsp.region = hmmbc_pkg::REG_CART_RAM;
				rsp.offset = (cfg.ctrl_type == hmmbc_pkg::CT_PLAIN) ?
					{8'd0, addr[12:0]} : {4'd0, cur.ram_sel, addr[12:0]};
			end else if (addr < hmmbc_pkg::ADDR_ECHO) begin
				rsp.region = hmmbc_pkg::REG_WRAM;
				rsp.offset = {8'd0, addr[12:0]};
			end else if (addr >= hmmbc_pkg::ADDR_OAM_LO && addr <= hmmbc_pkg::ADDR_OAM_HI) begin
				rsp.region = hmmbc_pkg::REG_OAM;
				rsp.offset = {13'd0, addr[7:0]};
			end else if (addr >= hmmbc_pkg::ADDR_IO_LO && addr <= hmmbc_pkg::ADDR_IO_HI) begin
				rsp.region = hmmbc_pkg::REG_IO;
				rsp.offset = {14'd0, addr[6:0]};
			end else if (addr >= hmmbc_pkg::ADDR_HRAM_LO &&
					addr <= hmmbc_pkg::ADDR_HRAM_HI) begin
				rsp.region = hmmbc_pkg::REG_HRAM;
				rsp.offset = {14'd0, addr[6:0]};
			end else if (addr == hmmbc_pkg::ADDR_IE) begin
				rsp.region = hmmbc_pkg::REG_IE;
			end else begin
				// echo space and the hole above the sprite table
				mapped  = 1'b0;
				rsp.err = hmmbc_pkg::ERR_UNMAPPED;
			end

			if (wr && mapped) begin
				rsp.store_en   = 1'b1;
				rsp.store_data = data;
				if (addr == hmmbc_pkg::ADDR_DIV) begin
					rsp.side       = hmmbc_pkg::SIDE_DIV_CLR;
					rsp.store_data = 8'd0;
				end else if (addr == hmmbc_pkg::ADDR_TAC) begin
					if (cur.tsel != data[1:0])
						rsp.side = hmmbc_pkg::SIDE_TIMER;
					nxt.tsel = data[1:0];
				end else if (addr == hmmbc_pkg::ADDR_LY) begin
					rsp.side       = hmmbc_pkg::SIDE_LINE_CLR;
					rsp.store_data = 8'd0;
				end else if (addr == hmmbc_pkg::ADDR_DMA) begin
					rsp.side       = hmmbc_pkg::SIDE_DMA_START;
					rsp.dma_page   = data;
					rsp.store_en   = 1'b0;
					rsp.store_data = 8'd0;
				end else if (addr == hmmbc_pkg::ADDR_BOOT_OFF) begin
					nxt.boot_off = (data != 8'd0);
				end
			end
		end

		rsp.ram_en = nxt.ram_en;
	end

endmodule

[src/handheld_memory_map_bank_controller_unit.sv]
// ----------------------------------------------------------------------------
// handheld_memory_map_bank_controller_unit: bus decoder and bank controller
// One result beat per bus access: region, offset, store request, side action
// and status; keeps the ROM/RAM bank, mode, RAM enable, boot and timer state.
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+-----------------------------------------
//   request  | req_valid | req_stall | command, address, data
//   response | rsp_valid | rsp_stall | region .. ram_enabled
//   config   | cfg_we    | -         | cfg_index, cfg_data
//
// One beat per cycle sustained unless the response stalls; each beat passes an
// input register, then a result register. The decode and bank update sit in
// one combinational stage between them, and bank state updates as a beat moves
// into the result register. Reset returns bank state and config to power-on
// values and empties both stages. A stalled response holds its stage; req_stall
// rises only when both stages are full and the response is stalled.
// ----------------------------------------------------------------------------
module handheld_memory_map_bank_controller_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        command,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [3:0]  region,
	output logic [20:0] physical_offset,
	output logic [7:0]  store_data,
	output logic        store_enable,
	output logic [2:0]  side_action,
	output logic [7:0]  dma_source_page,
	output logic [2:0]  error_code,
	output logic        ram_enabled
);

	hmmbc_pkg::cfg_t        cfg_q;
	hmmbc_pkg::bank_state_t state_q;
	hmmbc_pkg::bank_state_t state_nxt;
	hmmbc_pkg::rsp_t        rsp_nxt;
	hmmbc_pkg::rsp_t        rsp_s2;

	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;
	logic        valid_s2;
	logic        advance;
	logic        req_take;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	hmmbc_decode u_decode (
		.cmd  (cmd_s1),
		.addr (addr_s1),
		.data (data_s1),
		.cfg  (cfg_q),
		.cur  (state_q),
		.nxt  (state_nxt),
		.rsp  (rsp_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ctrl_type  <= hmmbc_pkg::CT_PLAIN;
			cfg_q.rom_count  <= hmmbc_pkg::MIN_ROM_BANKS;
			cfg_q.ram_count  <= hmmbc_pkg::MIN_RAM_BANKS;
			state_q.rom_sel  <= 7'd1;
			state_q.ram_sel  <= 4'd0;
			state_q.mode     <= 1'b0;
			state_q.ram_en   <= 1'b0;
			state_q.boot_off <= 1'b0;
			state_q.tsel     <= 2'd0;
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					hmmbc_pkg::CFG_CTRL_TYPE: cfg_q.ctrl_type <= cfg_data[1:0];
					hmmbc_pkg::CFG_ROM_COUNT: cfg_q.rom_count <= cfg_data;
					hmmbc_pkg::CFG_RAM_COUNT: cfg_q.ram_count <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (advance)
				state_q <= state_nxt;
			valid_s1 <= req_take || (valid_s1 && !advance);
			valid_s2 <= advance || (valid_s2 && rsp_stall);
		end
	end

	// payload stages: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_s1  <= command;
			addr_s1 <= address;
			data_s1 <= data;
		end
		if (advance)
			rsp_s2 <= rsp_nxt;
	end

	assign rsp_valid       = valid_s2;
	assign region          = rsp_s2.region;
	assign physical_offset = rsp_s2.offset;
	assign store_data      = rsp_s2.store_data;
	assign store_enable    = rsp_s2.store_en;
	assign side_action     = rsp_s2.side;
	assign dma_source_page = rsp_s2.dma_page;
	assign error_code      = rsp_s2.err;
	assign ram_enabled     = rsp_s2.ram_en;

	// input stage only stalls when it is full and cannot drain
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && rsp_stall))
		else $error("request stalled while a stage could drain");

	// an unsupported controller leaves the bank state alone
	a_bad_ctrl_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg_q.ctrl_type == hmmbc_pkg::CT_UNSUPPORTED) |=>
		$stable(state_q))
		else $error("bank state changed under unsupported controller");

	// a store always targets a mapped region
	a_store_mapped: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && store_enable) |-> (region != hmmbc_pkg::REG_NONE))
		else $error("store to unmapped region");

	// DMA start never stores
	a_dma_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && side_action == hmmbc_pkg::SIDE_DMA_START) |-> !store_enable)
		else $error("DMA start with store enabled");

	// ROM bank select never reads as zero
	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (state_q.rom_sel != 7'd0))
		else $error("ROM bank select is zero");

endmodule
